@@ sv/cvl_pkg.sv @@
package cvl_pkg;

  // Width of one stored value and of the element field.
  localparam int unsigned VALUE_W = 32;

  // Input kind codes.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_ELEMENT   = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_APPEND,
    OP_DELETE,
    OP_ROTATE
  } cvl_op_t;

  // Per-cell control: the shared operation plus the position flags of the cell.
  typedef struct packed {
    cvl_op_t op;
    logic    in_use;   // cell holds a stored value
    logic    is_tail;  // first free cell, target of an append
    logic    is_end;   // last occupied cell, takes the head value on rotation
  } cvl_cell_ctrl_t;

endpackage

@@ sv/cvl_cell.sv @@
module cvl_cell (
  input  logic                                 clk,
  input  cvl_pkg::cvl_cell_ctrl_t              ctrl,
  input  logic signed [cvl_pkg::VALUE_W-1:0]   key,
  input  logic signed [cvl_pkg::VALUE_W-1:0]   above,
  input  logic signed [cvl_pkg::VALUE_W-1:0]   wrap,
  input  logic                                 seen_in,
  output logic signed [cvl_pkg::VALUE_W-1:0]   value,
  output logic                                 seen_out
);

  logic signed [cvl_pkg::VALUE_W-1:0] value_r;
  logic signed [cvl_pkg::VALUE_W-1:0] value_nxt;
  logic                               hit;

  // A match counts only in an occupied cell; the running flag marks that this
  // cell or one below it holds the first match, so this cell closes the gap.
  assign hit      = ctrl.in_use && (value_r == key);
  assign seen_out = seen_in || hit;
  assign value    = value_r;

  always_comb begin
    value_nxt = value_r;
    case (ctrl.op)
      cvl_pkg::OP_APPEND: begin
        if (ctrl.is_tail) begin
          value_nxt = key;
        end
      end
      cvl_pkg::OP_DELETE: begin
        if (seen_out && ctrl.in_use) begin
          value_nxt = above;
        end
      end
      cvl_pkg::OP_ROTATE: begin
        if (ctrl.is_end) begin
          value_nxt = wrap;
        end else if (ctrl.in_use) begin
          value_nxt = above;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ sv/compacting_value_list.sv @@
// An append, delete or other request gives its single result in the output register
// in the cycle after its transfer; a list request gives its first element then.
// Throughput: one append or delete per cycle unless the output stalls; a list request
// holds the block until every stored value has gone out, one rotation per result.
// Reset (rst_n low at a clock edge) empties the list and the output register; the
// stored values themselves are not cleared, as the fill count alone marks them valid.
module compacting_value_list #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_kind,
  input  logic signed [cvl_pkg::VALUE_W-1:0]  in_value,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic signed [cvl_pkg::VALUE_W-1:0]  out_element,
  output logic [CntW-1:0]                     out_fill_count,
  output logic                                out_last
);

  // The block is either taking requests or walking the list for a list request.
  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  state_t                              state_r, state_nxt;
  logic [CntW-1:0]                     occ_r, occ_nxt;
  logic [CntW-1:0]                     rem_r, rem_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [2:0]                          out_status_r, out_status_nxt;
  logic signed [cvl_pkg::VALUE_W-1:0]  out_element_r, out_element_nxt;
  logic [CntW-1:0]                     out_fill_count_r, out_fill_count_nxt;
  logic                                out_last_r, out_last_nxt;

  logic                                out_free;
  logic                                in_xfer;
  cvl_pkg::cvl_op_t                    op;
  logic                                found;

  logic signed [cvl_pkg::VALUE_W-1:0]  cell_value [CAPACITY];
  logic                                seen [CAPACITY+1];
  logic signed [cvl_pkg::VALUE_W-1:0]  head;

  // The output register is free when it is empty or its result is being taken in
  // this cycle, so a new result can follow a waiting one without a bubble.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r == ST_LIST) || !out_free;
  assign in_xfer  = in_valid && !in_stall;

  assign head  = cell_value[0];
  assign found = seen[CAPACITY];

  // Operation for the cell chain this cycle. A rotation moves every stored value
  // down one place and wraps the head around to the end, so after as many
  // rotations as there are values the list is back in its original order.
  always_comb begin
    op = cvl_pkg::OP_HOLD;
    if (in_xfer) begin
      case (in_kind)
        cvl_pkg::KIND_APPEND: begin
          if (occ_r < CntW'(CAPACITY)) begin
            op = cvl_pkg::OP_APPEND;
          end
        end
        cvl_pkg::KIND_DELETE: begin
          op = cvl_pkg::OP_DELETE;
        end
        cvl_pkg::KIND_LIST: begin
          if (occ_r != '0) begin
            op = cvl_pkg::OP_ROTATE;
          end
        end
        default: begin
          op = cvl_pkg::OP_HOLD;
        end
      endcase
    end else if (state_r == ST_LIST && out_free) begin
      op = cvl_pkg::OP_ROTATE;
    end
  end

  // The chain of cells. The first-match flag ripples up from cell zero; on a delete,
  // every occupied cell at or above the first match takes its upper neighbor's value.
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cvl_pkg::cvl_cell_ctrl_t            ctrl;
    logic signed [cvl_pkg::VALUE_W-1:0] above;

    assign ctrl.op      = op;
    assign ctrl.in_use  = CntW'(i) < occ_r;
    assign ctrl.is_tail = CntW'(i) == occ_r;
    assign ctrl.is_end  = CntW'(i + 1) == occ_r;

    if (i == CAPACITY - 1) begin : g_top
      // The top cell has no upper neighbor; it only ever leaves use on a delete.
      assign above = cell_value[i];
    end else begin : g_mid
      assign above = cell_value[i+1];
    end

    cvl_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .key      (in_value),
      .above    (above),
      .wrap     (head),
      .seen_in  (seen[i]),
      .value    (cell_value[i]),
      .seen_out (seen[i+1])
    );
  end

  // Next-state and result logic.
  always_comb begin
    state_nxt          = state_r;
    occ_nxt            = occ_r;
    rem_nxt            = rem_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_status_nxt     = out_status_r;
    out_element_nxt    = out_element_r;
    out_fill_count_nxt = out_fill_count_r;
    out_last_nxt       = out_last_r;

    if (in_xfer) begin
      out_valid_nxt   = 1'b1;
      out_element_nxt = '0;
      out_last_nxt    = 1'b1;
      out_status_nxt  = cvl_pkg::STAT_OK;
      case (in_kind)
        cvl_pkg::KIND_APPEND: begin
          if (occ_r < CntW'(CAPACITY)) begin
            occ_nxt = occ_r + 1'b1;
          end else begin
            out_status_nxt = cvl_pkg::STAT_FULL;
          end
        end
        cvl_pkg::KIND_DELETE: begin
          if (found) begin
            occ_nxt = occ_r - 1'b1;
          end else begin
            out_status_nxt = cvl_pkg::STAT_NOT_FOUND;
          end
        end
        cvl_pkg::KIND_LIST: begin
          if (occ_r == '0) begin
            out_status_nxt = cvl_pkg::STAT_EMPTY;
          end else begin
            // The head goes out now; the remaining values follow one per cycle while the output does not stall.
            out_status_nxt  = cvl_pkg::STAT_ELEMENT;
            out_element_nxt = head;
            out_last_nxt    = (occ_r == CntW'(1));
            rem_nxt         = occ_r - 1'b1;
            if (occ_r != CntW'(1)) begin
              state_nxt = ST_LIST;
            end
          end
        end
        default: begin
          out_status_nxt = cvl_pkg::STAT_OK;
        end
      endcase
      out_fill_count_nxt = occ_nxt;
    end else if (state_r == ST_LIST && out_free) begin
      out_valid_nxt      = 1'b1;
      out_status_nxt     = cvl_pkg::STAT_ELEMENT;
      out_element_nxt    = head;
      out_fill_count_nxt = occ_r;
      out_last_nxt       = (rem_r == CntW'(1));
      rem_nxt            = rem_r - 1'b1;
      if (rem_r == CntW'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r     <= out_status_nxt;
    out_element_r    <= out_element_nxt;
    out_fill_count_r <= out_fill_count_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_element    = out_element_r;
  assign out_fill_count = out_fill_count_r;
  assign out_last       = out_last_r;

  // The fill count never passes the number of cells.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CntW'(CAPACITY))
    else $error("fill count exceeds capacity");

  // While the list is being walked, no new request may be taken.
  a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |-> in_stall)
    else $error("request taken during list walk");

  // An append that fits grows the list by exactly one.
  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_kind == cvl_pkg::KIND_APPEND && occ_r < CntW'(CAPACITY))
    |=> (occ_r == $past(occ_r) + 1'b1))
    else $error("append did not grow the list");

  // An empty-list result reports an empty store.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == cvl_pkg::STAT_EMPTY) |-> (out_fill_count_r == '0))
    else $error("empty result with nonzero fill count");

  // Only listed elements carry a nonzero element field.
  a_element_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != cvl_pkg::STAT_ELEMENT) |-> (out_element_r == '0))
    else $error("element field set on a non-element result");

endmodule
